### rtl/core/crc_gv_pkg.sv
// Shared types and constants for the programmable bit-serial CRC block.
package crc_gv_pkg;

    localparam int MAX_DEGREE = 32;
    localparam int REM_W      = MAX_DEGREE;
    localparam int DEG_W      = 6;
    localparam int IDX_W      = $clog2(MAX_DEGREE);
    localparam int CFG_W      = 32;

    localparam logic [REM_W-1:0] POLY_RESET   = REM_W'(3);
    localparam logic [DEG_W-1:0] DEGREE_RESET = DEG_W'(3);

    typedef enum logic [1:0] {
        REG_POLY   = 2'd0,
        REG_DEGREE = 2'd1,
        REG_MODE   = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        MODE_GENERATE = 1'b0,
        MODE_VERIFY   = 1'b1
    } crc_mode_t;

    typedef struct packed {
        logic message_bit;
        logic is_last;
    } in_item_t;

    typedef struct packed {
        logic out_bit;
        logic is_check_bit;
        logic message_ok;
        logic is_verdict;
        logic out_last;
    } out_item_t;

    // Settings as the datapath sees them, already clamped and masked
    typedef struct packed {
        logic [REM_W-1:0] poly;
        logic [REM_W-1:0] mask;
        logic [DEG_W-1:0] degree;
        logic [IDX_W-1:0] top_idx;
        crc_mode_t        mode;
    } crc_cfg_t;

endpackage

### rtl/core/crc_gv_cfg.sv
// Configuration registers with effective degree, mask and polynomial.
module crc_gv_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  crc_gv_pkg::cfg_idx_t              cfg_index,
    input  logic [crc_gv_pkg::CFG_W-1:0]      cfg_data,
    output crc_gv_pkg::crc_cfg_t              cfg
);
    import crc_gv_pkg::*;

    logic [REM_W-1:0] poly_reg;
    logic [DEG_W-1:0] degree_reg;
    crc_mode_t        mode_reg;
    logic [DEG_W-1:0] deg_eff;
    logic [DEG_W-1:0] deg_m1;
    logic [REM_W-1:0] mask;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= POLY_RESET;
            degree_reg <= DEGREE_RESET;
            mode_reg   <= MODE_GENERATE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POLY:   poly_reg   <= cfg_data[REM_W-1:0];
                REG_DEGREE: degree_reg <= cfg_data[DEG_W-1:0];
                REG_MODE:   mode_reg   <= crc_mode_t'(cfg_data[0]);
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        // zero degree acts as one, anything past the maximum is clamped
        if (degree_reg == '0)
            deg_eff = DEG_W'(1);
        else if (degree_reg > DEG_W'(MAX_DEGREE))
            deg_eff = DEG_W'(MAX_DEGREE);
        else
            deg_eff = degree_reg;
        deg_m1 = deg_eff - DEG_W'(1);
        if (deg_eff >= DEG_W'(REM_W))
            mask = '1;
        else
            mask = (REM_W'(1) << deg_eff) - REM_W'(1);
    end

    assign cfg.poly    = poly_reg & mask;
    assign cfg.mask    = mask;
    assign cfg.degree  = deg_eff;
    assign cfg.top_idx = deg_m1[IDX_W-1:0];
    assign cfg.mode    = mode_reg;

endmodule

### rtl/core/crc_gv_core.sv
// Input register, remainder update, check-bit emitter and result register.
module crc_gv_core (
    input  logic                    clk,
    input  logic                    rst_n,
    input  crc_gv_pkg::crc_cfg_t    cfg,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  crc_gv_pkg::in_item_t    in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output crc_gv_pkg::out_item_t   out_data
);
    import crc_gv_pkg::*;

    logic             in_valid_reg;
    in_item_t         in_reg;
    logic [REM_W-1:0] remainder_reg;
    logic [REM_W-1:0] chk_reg;
    logic [DEG_W-1:0] emit_count_reg;
    logic [DEG_W-1:0] emit_m1;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic             adv;
    logic             emitting;
    logic             no_result;
    logic             process;
    logic             emit_step;
    logic [REM_W-1:0] r_cur;
    logic             top;
    logic [REM_W-1:0] r_next;
    out_item_t        step_item;
    out_item_t        chk_item;

    assign adv       = !out_valid_reg || out_ready;
    assign emitting  = (emit_count_reg != '0);
    assign no_result = (cfg.mode == MODE_VERIFY) && !in_reg.is_last;
    assign process   = in_valid_reg && !emitting && (adv || no_result);
    assign emit_step = emitting && adv;
    assign in_ready  = !in_valid_reg || process;
    assign emit_m1   = emit_count_reg - DEG_W'(1);

    always_comb
    begin
        r_cur = remainder_reg & cfg.mask;
        top   = r_cur[cfg.top_idx];
        if (cfg.mode == MODE_GENERATE)
        begin
            r_next = (r_cur << 1) & cfg.mask;
            if (top ^ in_reg.message_bit)
                r_next = r_next ^ cfg.poly;
        end
        else
        begin
            r_next = ((r_cur << 1) | REM_W'(in_reg.message_bit)) & cfg.mask;
            if (top)
                r_next = r_next ^ cfg.poly;
        end

        step_item = '0;
        if (cfg.mode == MODE_GENERATE)
        begin
            step_item.out_bit = in_reg.message_bit;
        end
        else
        begin
            step_item.message_ok = (r_next == '0);
            step_item.is_verdict = 1'b1;
            step_item.out_last   = 1'b1;
        end

        // check bits go out most significant first, counting down
        chk_item              = '0;
        chk_item.out_bit      = chk_reg[emit_m1[IDX_W-1:0]];
        chk_item.is_check_bit = 1'b1;
        chk_item.out_last     = (emit_count_reg == DEG_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            remainder_reg  <= '0;
            emit_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;

            if (process)
                remainder_reg <= in_reg.is_last ? '0 : r_next;

            if (emit_step)
                emit_count_reg <= emit_m1;
            else if (process && in_reg.is_last && (cfg.mode == MODE_GENERATE))
                emit_count_reg <= cfg.degree;

            if (emit_step || (process && !no_result))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_reg <= in_data;
        if (process && in_reg.is_last)
            chk_reg <= r_next;
        if (emit_step)
            out_reg <= chk_item;
        else if (process && !no_result)
            out_reg <= step_item;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### rtl/core/crc_generate_verify.sv
// Top level of the programmable bit-serial CRC generator and checker.
//
// Usage:
//   Input requests carry one message bit each, most significant first, with
//   is_last on the final bit. Result requests leave on the output channel.
//   The configuration port (polynomial, degree, mode) is written while idle.
//   Generate mode echoes each bit; after the last bit the degree check bits
//   follow, most significant first, the final one flagged out_last.
//   Verify mode gives one verdict request after the last bit, nothing before.
// Throughput: one bit per cycle, set by the single-level remainder update,
//   while results are not stalled. After the last bit in generate mode, input
//   stalls while the check-bit counter drains.
// An input register and the result register let one request be taken while
// a finished result waits; a stalled receiver backs up into in_ready.
// Reset clears the remainder, the check-bit counter and both valid flags,
// and loads the polynomial x^3+x+1 in generate mode.
module crc_generate_verify (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  crc_gv_pkg::cfg_idx_t              cfg_index,
    input  logic [crc_gv_pkg::CFG_W-1:0]      cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  crc_gv_pkg::in_item_t              in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output crc_gv_pkg::out_item_t             out_data
);
    import crc_gv_pkg::*;

    crc_cfg_t cfg;

    crc_gv_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    crc_gv_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

### rtl/core/crc_gv_checker.sv
// Port-level checks on the CRC block's result stream, bound to the top level.
module crc_gv_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  crc_gv_pkg::out_item_t   out_data
);
    import crc_gv_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // check bits come in an unbroken run up to the one flagged last
    a_chk_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.is_check_bit && !out_data.out_last
        |=> out_valid && out_data.is_check_bit)
        else $error("check-bit run broken");

    a_verdict_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_verdict
        |-> !out_data.is_check_bit && !out_data.out_bit && out_data.out_last)
        else $error("malformed verdict");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.out_last
        |-> out_data.is_check_bit || out_data.is_verdict)
        else $error("last flag on echoed bit");

    a_ok_only_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.message_ok |-> out_data.is_verdict)
        else $error("message_ok outside verdict");

endmodule

bind crc_generate_verify crc_gv_checker u_crc_gv_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
